>>> src/gopd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gopd_pkg;

	// Default depth of the flag run store
	localparam int MAX_POINTS_DEF = 1024;

	// Fixed field widths
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int COORD_W = 18;
	localparam int RUN_W   = 9;
	localparam int FLAG_W  = 6;

	// Stream word widths
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	// One stored flag run: repeat count over the six flag bits
	typedef struct packed {
		logic [BYTE_W-1:0] rep;
		logic [FLAG_W-1:0] flag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

>>> src/gopd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gopd_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word; read the old contents into the output register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

>>> src/glyph_outline_point_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes the point part of a simple glyph outline at one stream byte per
// clock while the master side accepts beats: a beat is taken into an input
// register and processed into a result register once that register can take
// it. The slave beat carries the byte in tdata[7:0], the point count in
// tdata[18:8] and glyph start in tuser; the count is read only on a start
// beat. Flag bytes and repeat bytes build a run store of 2^clog2(MAX_POINTS)
// entries; the x deltas then the y deltas follow and each point's absolute
// coordinate leaves as one master beat. The first byte of a 16-bit delta
// yields no beat. A point whose flag says "same" without "short" consumes a
// beat without using its byte, so the feeder must send a filler byte there.
// The run store is read one run ahead through its registered port, so a
// one-point run does not stall the stream. It needs no clearing after reset:
// every run is written before it is read.
module glyph_outline_point_decoder
	import gopd_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // data_byte[7:0], point_count[18:8], zero
	input  wire logic                s_tuser,  // glyph_start
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // point_index[9:0], coordinate[27:10],
	                                           // on_curve[28], overrun[29], zero
	output logic                     m_tuser,  // axis
	output logic                     m_tlast   // last
);

	localparam int AW     = $clog2(MAX_POINTS);
	localparam int MaxCap = (MAX_POINTS > 2047) ? 2047 : MAX_POINTS;
	localparam logic [COUNT_W-1:0] MAX_PC = COUNT_W'(MaxCap);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FLAG,
		PH_REPEAT,
		PH_X,
		PH_XHI,
		PH_Y,
		PH_YHI
	} phase_t;

	// Input stage
	logic               s1_valid_q;
	logic [BYTE_W-1:0]  byte_s1;
	logic [COUNT_W-1:0] count_s1;
	logic               start_s1;

	// Output stage
	logic               m_valid_s2;
	logic               axis_s2;
	logic [INDEX_W-1:0] index_s2;
	logic [COORD_W-1:0] coord_s2;
	logic               on_curve_s2;
	logic               last_s2;
	logic               overrun_s2;

	// Decoder state
	phase_t             ph_q, ph_d;
	logic [COUNT_W-1:0] pe_q, pe_d;
	logic [COUNT_W-1:0] pc_q, pc_d;
	logic [COUNT_W-1:0] rt_q, rt_d;
	logic               ovr_q, ovr_d;
	logic [AW-1:0]      rp_q, rp_d;
	logic [RUN_W-1:0]   rl_q, rl_d;
	logic [COORD_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0]  hi_q, hi_d;
	entry_t             cur_q, cur_d;
	entry_t             e0_q, e0_d;
	logic [FLAG_W-1:0]  flag_q, flag_d;
	logic               byp_sel_q;
	entry_t             byp_data_q;

	// Run store access
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_data;
	logic [AW-1:0]      rd_addr;
	entry_t             ram_rd;
	entry_t             nxt;

	// Step results
	logic               fire;
	logic               emit;
	logic               e_axis;
	logic               e_last;
	logic [COORD_W-1:0] coord_e;

	// Hand-shake: a beat is processed once the result register can take it
	assign fire     = s1_valid_q && (!m_valid_s2 || m_tready);
	assign s_tready = !s1_valid_q || fire;

	assign m_tvalid = m_valid_s2;
	assign m_tuser  = axis_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = {2'b00, overrun_s2, on_curve_s2, coord_s2, index_s2};

	// Next run comes from the store unless it was written at its address as the read was issued
	assign nxt = byp_sel_q ? byp_data_q : ram_rd;

	gopd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(1 << AW)
	) u_runs (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	// Decode one byte
	always_comb begin
		phase_t             ph_e;
		logic [COUNT_W-1:0] pe_e;
		logic [COUNT_W-1:0] pc_e;
		logic [COUNT_W-1:0] rt_e;
		logic               ovr_e;
		logic [COUNT_W-1:0] rem;
		logic [COUNT_W-1:0] pc_inc;
		logic [BYTE_W-1:0]  r;
		logic [15:0]        v;
		logic               ax;
		logic               shrt;
		logic               same;
		logic               go_x;
		logic               go_y;

		ph_e   = start_s1 ? PH_FLAG : ph_q;
		pe_e   = pe_q;
		pc_e   = start_s1 ? '0 : pc_q;
		rt_e   = start_s1 ? '0 : rt_q;
		ovr_e  = start_s1 ? 1'b0 : ovr_q;
		rem    = '0;
		pc_inc = '0;
		r      = '0;
		v      = '0;
		ax     = 1'b0;
		shrt   = 1'b0;
		same   = 1'b0;
		go_x   = 1'b0;
		go_y   = 1'b0;

		ph_d    = ph_q;
		pe_d    = pe_q;
		pc_d    = pc_q;
		rt_d    = rt_q;
		ovr_d   = ovr_q;
		rp_d    = rp_q;
		rl_d    = rl_q;
		sum_d   = sum_q;
		hi_d    = hi_q;
		cur_d   = cur_q;
		e0_d    = e0_q;
		flag_d  = flag_q;
		wr_en   = 1'b0;
		wr_data = '0;
		emit    = 1'b0;
		e_axis  = 1'b0;
		e_last  = 1'b0;
		coord_e = sum_q;

		if (start_s1) begin
			if (count_s1 == '0) begin
				pe_e = COUNT_W'(1);
			end else if (count_s1 > MAX_PC) begin
				pe_e = MAX_PC;
			end else begin
				pe_e = count_s1;
			end
		end

		if (fire) begin
			ph_d  = ph_e;
			pe_d  = pe_e;
			pc_d  = pc_e;
			rt_d  = rt_e;
			ovr_d = ovr_e;
			if (start_s1) begin
				rp_d  = '0;
				rl_d  = '0;
				sum_d = '0;
				hi_d  = '0;
			end

			unique case (ph_e)
				PH_IDLE: begin
				end
				PH_FLAG: begin
					wr_en        = 32'(rt_e) < 32'(MAX_POINTS);
					wr_data.rep  = '0;
					wr_data.flag = byte_s1[FLAG_W-1:0];
					flag_d       = byte_s1[FLAG_W-1:0];
					pc_inc       = pc_e + COUNT_W'(1);
					pc_d         = pc_inc;
					if (byte_s1[3]) begin
						ph_d = PH_REPEAT;
					end else begin
						rt_d = rt_e + COUNT_W'(1);
						go_x = pc_inc >= pe_e;
					end
				end
				PH_REPEAT: begin
					rem = pe_e - pc_e;
					r   = byte_s1;
					if (COUNT_W'(byte_s1) > rem) begin
						ovr_d = 1'b1;
						r     = rem[BYTE_W-1:0];
					end
					wr_en        = 32'(rt_e) < 32'(MAX_POINTS);
					wr_data.rep  = r;
					wr_data.flag = flag_q;
					pc_inc       = pc_e + COUNT_W'(r);
					pc_d         = pc_inc;
					rt_d         = rt_e + COUNT_W'(1);
					if (pc_inc >= pe_e) begin
						go_x = 1'b1;
					end else begin
						ph_d = PH_FLAG;
					end
				end
				PH_XHI, PH_YHI: begin
					ax      = ph_e == PH_YHI;
					v       = {hi_q, byte_s1};
					coord_e = sum_q + {{(COORD_W-16){v[15]}}, v};
					emit    = 1'b1;
					ph_d    = ax ? PH_Y : PH_X;
				end
				PH_X, PH_Y: begin
					ax   = ph_e == PH_Y;
					shrt = ax ? cur_q.flag[2] : cur_q.flag[1];
					same = ax ? cur_q.flag[5] : cur_q.flag[4];
					if (shrt) begin
						coord_e = same ? sum_q + COORD_W'(byte_s1) : sum_q - COORD_W'(byte_s1);
						emit    = 1'b1;
					end else if (same) begin
						emit = 1'b1;
					end else begin
						hi_d = byte_s1;
						ph_d = ax ? PH_YHI : PH_XHI;
					end
				end
				default: begin
				end
			endcase

			// Keep run zero at hand for the start of each axis
			if (wr_en && rt_e == '0) begin
				e0_d = wr_data;
			end

			// Emit the point, then step to the next point, run or axis
			if (emit) begin
				sum_d  = coord_e;
				e_axis = ax;
				pc_inc = pc_e + COUNT_W'(1);
				e_last = ax && (pc_inc >= pe_e);
				pc_d   = pc_inc;
				if (pc_inc >= pe_e) begin
					if (!ax) begin
						go_y = 1'b1;
					end else begin
						ph_d = PH_IDLE;
					end
				end else if (rl_q == RUN_W'(1)) begin
					rp_d  = rp_q + AW'(1);
					cur_d = nxt;
					rl_d  = RUN_W'(nxt.rep) + RUN_W'(1);
				end else begin
					rl_d = rl_q - RUN_W'(1);
				end
			end

			if (go_x || go_y) begin
				ph_d  = go_x ? PH_X : PH_Y;
				pc_d  = '0;
				rp_d  = '0;
				sum_d = '0;
				cur_d = e0_d;
				rl_d  = RUN_W'(e0_d.rep) + RUN_W'(1);
			end
		end
	end

	// Read one run ahead of the pointer
	assign wr_addr = AW'(rt_q & {COUNT_W{1'b0}}) | AW'(start_s1 ? '0 : rt_q);
	assign rd_addr = rp_d + AW'(1);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_s2 <= 1'b0;
			ph_q       <= PH_IDLE;
			pe_q       <= '0;
			pc_q       <= '0;
			rt_q       <= '0;
			ovr_q      <= 1'b0;
			rp_q       <= '0;
			rl_q       <= '0;
			sum_q      <= '0;
			hi_q       <= '0;
			byp_sel_q  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire && emit) begin
				m_valid_s2 <= 1'b1;
			end else if (m_tready) begin
				m_valid_s2 <= 1'b0;
			end
			ph_q      <= ph_d;
			pe_q      <= pe_d;
			pc_q      <= pc_d;
			rt_q      <= rt_d;
			ovr_q     <= ovr_d;
			rp_q      <= rp_d;
			rl_q      <= rl_d;
			sum_q     <= sum_d;
			hi_q      <= hi_d;
			byp_sel_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata[BYTE_W-1:0];
			count_s1 <= s_tdata[BYTE_W +: COUNT_W];
			start_s1 <= s_tuser;
		end
		if (fire && emit) begin
			axis_s2     <= e_axis;
			index_s2    <= pc_q[INDEX_W-1:0];
			coord_s2    <= coord_e;
			on_curve_s2 <= cur_q.flag[0];
			last_s2     <= e_last;
			overrun_s2  <= ovr_q;
		end
		cur_q      <= cur_d;
		e0_q       <= e0_d;
		flag_q     <= flag_d;
		byp_data_q <= wr_data;
	end

`ifndef SYNTH
	// Only a y coordinate closes a glyph
	a_last_on_y: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("last beat on x axis");

	// A run in use always has points left
	a_run_left: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_X || ph_q == PH_Y || ph_q == PH_XHI || ph_q == PH_YHI) |-> rl_q != '0)
		else $error("empty run during coordinate decode");

	// The point counter stays below the point count while decoding
	a_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_X || ph_q == PH_Y || ph_q == PH_XHI || ph_q == PH_YHI) |-> pc_q < pe_q)
		else $error("point counter past point count");

	// The final y coordinate drops the decoder to idle
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit && e_last |=> ph_q == PH_IDLE)
		else $error("decoder not idle after last point");
`endif

endmodule

`default_nettype wire
